// ===== rtl/mt19937_word_generator_assert.svh =====
// ----------------------------------------------------------------------------
// mt19937_word_generator_assert.svh
// assertion macros for the word generator; empty under synthesis
// ----------------------------------------------------------------------------
`ifndef MT19937_WORD_GENERATOR_ASSERT_SVH
`define MT19937_WORD_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MTW_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtw assertion failed");

// next-cycle implication
`define MTW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtw assertion failed");

`else

`define MTW_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define MTW_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/mtw_pkg.sv =====
// ----------------------------------------------------------------------------
// mtw_pkg
// shared constants, types and functions of the mt19937 word generator
// ----------------------------------------------------------------------------
`default_nettype none

package mtw_pkg;

    localparam int unsigned MTW_STATE_WORDS  = 624;
    localparam int unsigned MTW_SHIFT_OFFSET = 397;
    localparam int unsigned MTW_WORD_W       = 32;

    localparam logic [31:0] MTW_TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [31:0] MTW_TEMPER_B     = 32'h9d2c_5680;
    localparam logic [31:0] MTW_TEMPER_C     = 32'hefc6_0000;
    localparam logic [16:0] MTW_LCG_MUL      = 17'd69069;
    localparam logic [31:0] MTW_DEFAULT_SEED = 32'd4357;

    // request kind carried on tuser
    localparam logic MTW_KIND_DRAW = 1'b0;
    localparam logic MTW_KIND_SEED = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL_HI,
        ST_FILL_LO,
        ST_PRIME,
        ST_LOAD,
        ST_TW_RD,
        ST_TW_WR,
        ST_DRAW_RD,
        ST_DRAW_WAIT
    } mtw_state_t;

    function automatic logic [31:0] mtw_temper(input logic [31:0] y_in);
        logic [31:0] y;
        y = y_in;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & MTW_TEMPER_B);
        y = y ^ ((y << 15) & MTW_TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // one twist step: current word, its successor, and the word offset ahead
    function automatic logic [31:0] mtw_twist(input logic [31:0] cur,
                                              input logic [31:0] nxt,
                                              input logic [31:0] far);
        logic [31:0] y;
        logic [31:0] v;
        y = {cur[31], nxt[30:0]};
        v = far ^ {1'b0, y[31:1]};
        if (y[0])
        begin
            v = v ^ MTW_TWIST_MATRIX;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mt19937_word_generator.sv =====
// ----------------------------------------------------------------------------
// mt19937_word_generator
// 32-bit mersenne twister with congruential seeding, one word per draw
// ----------------------------------------------------------------------------
// draw, buffer not used up: ST_DRAW_RD, then ST_DRAW_WAIT, which waits for
// a free result register; draw that needs a new twist: prime, load, twist, draw
// seed transaction: fill and twist of the state, no result; s_tready only in idle
// fill takes FILL_HI then FILL_LO a word; twist takes TW_RD then TW_WR a word,
// set by the state memory ports (two reads and one write per word on the shared twist unit)
// rst_n clears control only; a draw before any seed seeds with 4357
`default_nettype none

module mt19937_word_generator #(
    parameter int unsigned STATE_WORDS  = mtw_pkg::MTW_STATE_WORDS,
    parameter int unsigned SHIFT_OFFSET = mtw_pkg::MTW_SHIFT_OFFSET
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request side
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] seed_value
    input  wire logic        s_tuser,   // [0] kind
    // result side
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata    // [31:0] random_value
);

    import mtw_pkg::*;

    `include "mt19937_word_generator_assert.svh"

    localparam int unsigned ADDR_W = $clog2(STATE_WORDS);
    localparam int unsigned POS_W  = $clog2(STATE_WORDS + 1);

    localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(STATE_WORDS - 1);
    localparam logic [ADDR_W:0]   DEPTH_X   = (ADDR_W+1)'(STATE_WORDS);
    localparam logic [ADDR_W:0]   OFFSET_X  = (ADDR_W+1)'(SHIFT_OFFSET);
    localparam logic [POS_W-1:0]  POS_END   = POS_W'(STATE_WORDS);

    // control registers
    mtw_state_t        state_reg, state_next;
    logic [POS_W-1:0]  pos_reg, pos_next;           // next word to hand out
    logic              seeded_reg, seeded_next;
    logic              pend_reg, pend_next;         // draw waits for a twist
    logic              out_valid_reg, out_valid_next;

    // datapath registers
    logic [ADDR_W-1:0] k_reg, k_next;               // fill / twist word index
    logic [31:0]       x_reg, x_next;               // congruential value
    logic [15:0]       hi_reg, hi_next;             // high half of fill word
    logic [31:0]       cur_reg, cur_next;           // word k before its twist
    logic [31:0]       out_data_reg, out_data_next;

    // memory port signals
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [31:0]       ram_wdata;
    logic [ADDR_W-1:0] ram_raddr_a;
    logic [ADDR_W-1:0] ram_raddr_b;
    logic [31:0]       ram_rdata_a;
    logic [31:0]       ram_rdata_b;

    // shared arithmetic
    logic [31:0]       lcg_prod;
    logic [31:0]       lcg_value;
    logic [ADDR_W-1:0] nxt_idx;
    logic [ADDR_W:0]   far_sum;
    logic [ADDR_W-1:0] far_idx;
    logic              s_hs;

    mtw_state_ram #(
        .DEPTH  (STATE_WORDS),
        .WIDTH  (MTW_WORD_W),
        .ADDR_W (ADDR_W)
    ) u_state_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    // x = 69069 * x + 1, low 32 bits kept
    assign lcg_prod  = x_reg * MTW_LCG_MUL;
    assign lcg_value = lcg_prod + 32'd1;

    // successor index wraps to word 0 after the last word
    assign nxt_idx = (k_reg == LAST_IDX) ? '0 : k_reg + ADDR_W'(1);

    // far index: k + offset, folded back once below the depth
    assign far_sum = {1'b0, k_reg} + OFFSET_X;
    always_comb
    begin
        if (far_sum >= DEPTH_X)
        begin
            far_idx = ADDR_W'(far_sum - DEPTH_X);
        end
        else
        begin
            far_idx = far_sum[ADDR_W-1:0];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_hs     = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= POS_END;
            seeded_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            seeded_reg    <= seeded_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        x_reg        <= x_next;
        hi_reg       <= hi_next;
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        seeded_next    = seeded_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        k_next         = k_reg;
        x_next         = x_reg;
        hi_next        = hi_reg;
        cur_next       = cur_reg;
        out_data_next  = out_data_reg;

        ram_we      = 1'b0;
        ram_waddr   = k_reg;
        ram_wdata   = mtw_twist(cur_reg, ram_rdata_a, ram_rdata_b);
        ram_raddr_a = pos_reg[ADDR_W-1:0];
        ram_raddr_b = far_idx;

        // result register drains independently of the sequencer
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_hs)
                begin
                    k_next = '0;
                    if (s_tuser == MTW_KIND_SEED)
                    begin
                        x_next     = s_tdata;
                        pend_next  = 1'b0;
                        state_next = ST_FILL_HI;
                    end
                    else if (pos_reg >= POS_END)
                    begin
                        // buffer used up: refill before the draw
                        pend_next = 1'b1;
                        if (!seeded_reg)
                        begin
                            x_next     = MTW_DEFAULT_SEED;
                            state_next = ST_FILL_HI;
                        end
                        else
                        begin
                            state_next = ST_PRIME;
                        end
                    end
                    else
                    begin
                        state_next = ST_DRAW_RD;
                    end
                end
            end

            ST_FILL_HI:
            begin
                hi_next    = x_reg[31:16];
                x_next     = lcg_value;
                state_next = ST_FILL_LO;
            end

            ST_FILL_LO:
            begin
                ram_we     = 1'b1;
                ram_wdata  = {hi_reg, x_reg[31:16]};
                x_next     = lcg_value;
                if (k_reg == LAST_IDX)
                begin
                    seeded_next = 1'b1;
                    state_next  = ST_PRIME;
                end
                else
                begin
                    k_next     = k_reg + ADDR_W'(1);
                    state_next = ST_FILL_HI;
                end
            end

            ST_PRIME:
            begin
                // fetch word 0 as the first current word
                ram_raddr_a = '0;
                state_next  = ST_LOAD;
            end

            ST_LOAD:
            begin
                cur_next   = ram_rdata_a;
                k_next     = '0;
                state_next = ST_TW_RD;
            end

            ST_TW_RD:
            begin
                ram_raddr_a = nxt_idx;
                ram_raddr_b = far_idx;
                state_next  = ST_TW_WR;
            end

            ST_TW_WR:
            begin
                // successor read in this word's turn becomes the next current word
                ram_we   = 1'b1;
                cur_next = ram_rdata_a;
                if (k_reg == LAST_IDX)
                begin
                    pos_next = '0;
                    if (pend_reg)
                    begin
                        state_next = ST_DRAW_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    k_next     = k_reg + ADDR_W'(1);
                    state_next = ST_TW_RD;
                end
            end

            ST_DRAW_RD:
            begin
                pend_next  = 1'b0;
                state_next = ST_DRAW_WAIT;
            end

            ST_DRAW_WAIT:
            begin
                // read address still holds pos, so the read data stays put
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = mtw_temper(ram_rdata_a);
                    out_valid_next = 1'b1;
                    pos_next       = pos_reg + POS_W'(1);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // read position never runs past the end of the state
    `MTW_ASSERT_IMPLY(a_pos_range, clk, rst_n, 1'b1, pos_reg <= POS_END)

    // a finished twist restarts the read position at word 0
    `MTW_ASSERT_NEXT(a_twist_end_pos, clk, rst_n,
        (state_reg == ST_TW_WR) && (k_reg == LAST_IDX), pos_reg == '0)

    // a draw before any seed starts the default fill
    `MTW_ASSERT_NEXT(a_default_seed, clk, rst_n,
        s_hs && (s_tuser == MTW_KIND_DRAW) && !seeded_reg,
        (state_reg == ST_FILL_HI) && (x_reg == MTW_DEFAULT_SEED))

    // a result is never loaded over one still waiting
    `MTW_ASSERT_NEXT(a_no_overwrite, clk, rst_n,
        out_valid_reg && !m_tready, out_valid_reg && $stable(out_data_reg))

endmodule

`default_nettype wire

// ===== rtl/mtw_state_ram.sv =====
// ----------------------------------------------------------------------------
// mtw_state_ram
// twister state memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module mtw_state_ram #(
    parameter int unsigned DEPTH  = 624,
    parameter int unsigned WIDTH  = 32,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr_a,
    input  wire logic [ADDR_W-1:0] raddr_b,
    output logic      [WIDTH-1:0]  rdata_a,
    output logic      [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire
